// ===== src/rtch_pkg.sv =====
package rtch_pkg;

   localparam int CoordW = 32;
   localparam int EdgeW  = 33;
   localparam int ProdW  = 66;
   localparam int CrossW = 67;
   localparam int WideW  = 128;
   localparam int QuoW   = 48;

   localparam logic [2:0] CsrOriginX = 3'd0;
   localparam logic [2:0] CsrOriginY = 3'd1;
   localparam logic [2:0] CsrOriginZ = 3'd2;
   localparam logic [2:0] CsrDirX    = 3'd3;
   localparam logic [2:0] CsrDirY    = 3'd4;
   localparam logic [2:0] CsrDirZ    = 3'd5;
   localparam logic [2:0] CsrEps     = 3'd6;

   typedef struct packed {
      logic signed [31:0] v0_x;
      logic signed [31:0] v0_y;
      logic signed [31:0] v0_z;
      logic signed [31:0] v1_x;
      logic signed [31:0] v1_y;
      logic signed [31:0] v1_z;
      logic signed [31:0] v2_x;
      logic signed [31:0] v2_y;
      logic signed [31:0] v2_z;
      logic               first_of_query;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_t;
      logic        closest_valid;
      logic [31:0] closest_t;
   } rsp_type;

   typedef enum logic [2:0] {
      OpLoad, OpCross, OpDot, OpSign, OpDivStep, OpFinish
   } op_type;

   typedef struct packed {
      logic   go;
      op_type op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic hit;
   } sts_type;

endpackage

// ===== src/rtch_datapath.sv =====
module rtch_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  rtch_pkg::req_type req,
   input  rtch_pkg::cmd_type cmd,
   output rtch_pkg::sts_type sts,
   output rtch_pkg::rsp_type rsp
);
   import rtch_pkg::*;

   logic signed [31:0] org_ff [3];
   logic signed [31:0] dir_ff [3];
   logic [31:0]        eps_ff;
   logic signed [EdgeW-1:0] e1_ff [3], e2_ff [3], tv_ff [3];
   logic signed [CrossW-1:0] p_ff [3], q_ff [3];
   logic signed [WideW-1:0] det_ff, nu_ff, nv_ff, nt_ff;
   logic [WideW-1:0] rem_ff, num_ff, mag_ff;
   logic [QuoW-1:0]  quo_ff;
   logic             ovf_ff;
   logic             hit_ff;
   logic [31:0]      best_t_ff;
   logic             best_found_ff;
   logic             first_ff;

   logic signed [CrossW-1:0] cr [3];
   logic signed [33:0]       ps [3], qs [3];
   logic signed [WideW-1:0]  dt [4];
   logic signed [WideW-1:0]  mag_c, nu_c, nv_c, nt_c;
   logic                     hit_c;
   logic [WideW-1:0] rem_sh, rem_sub;
   logic [31:0] t_sat;

   function automatic logic signed [EdgeW-1:0] sx(input logic signed [31:0] a);
      return EdgeW'(a);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         automatic int j = (i + 1) % 3;
         automatic int k = (i + 2) % 3;
         if (cmd.sel == 2'd0)
            cr[i] = CrossW'(sx(dir_ff[j]) * e2_ff[k]) - CrossW'(sx(dir_ff[k]) * e2_ff[j]);
         else
            cr[i] = CrossW'(tv_ff[j] * e1_ff[k]) - CrossW'(tv_ff[k] * e1_ff[j]);
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.sel == 2'd0) begin
            ps[i] = {1'b0, p_ff[i][32:0]};
            qs[i] = {1'b0, q_ff[i][32:0]};
         end else begin
            ps[i] = p_ff[i][CrossW-1:33];
            qs[i] = q_ff[i][CrossW-1:33];
         end
      end
      for (int n = 0; n < 4; n++) dt[n] = '0;
      for (int i = 0; i < 3; i++) begin
         dt[0] = dt[0] + WideW'(e1_ff[i] * ps[i]);
         dt[1] = dt[1] + WideW'(tv_ff[i] * ps[i]);
         dt[2] = dt[2] + WideW'(sx(dir_ff[i]) * qs[i]);
         dt[3] = dt[3] + WideW'(e2_ff[i] * qs[i]);
      end
      mag_c = det_ff[WideW-1] ? -det_ff : det_ff;
      nu_c  = det_ff[WideW-1] ? -nu_ff : nu_ff;
      nv_c  = det_ff[WideW-1] ? -nv_ff : nv_ff;
      nt_c  = det_ff[WideW-1] ? -nt_ff : nt_ff;
      hit_c = (mag_c > {64'd0, eps_ff, 32'd0}) && !nu_c[WideW-1] && (nu_c <= mag_c)
              && !nv_c[WideW-1] && ((nu_c + nv_c) <= mag_c) && !nt_c[WideW-1];
      rem_sh  = {rem_ff[WideW-2:0], num_ff[WideW-1]};
      rem_sub = rem_sh - mag_ff;
      t_sat   = (ovf_ff || (quo_ff[QuoW-1:32] != '0)) ? '1 : quo_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{default: '0};
         dir_ff <= '{32'sd0, 32'sd0, 32'sd65536};
         eps_ff <= '0;
         best_t_ff <= '1;
         best_found_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrOriginX: org_ff[0] <= csr_wdata;
               CsrOriginY: org_ff[1] <= csr_wdata;
               CsrOriginZ: org_ff[2] <= csr_wdata;
               CsrDirX:    dir_ff[0] <= csr_wdata;
               CsrDirY:    dir_ff[1] <= csr_wdata;
               CsrDirZ:    dir_ff[2] <= csr_wdata;
               CsrEps:     eps_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.go) begin
            case (cmd.op)
               OpLoad: begin
                  e1_ff[0] <= sx(req.v1_x) - sx(req.v0_x);
                  e1_ff[1] <= sx(req.v1_y) - sx(req.v0_y);
                  e1_ff[2] <= sx(req.v1_z) - sx(req.v0_z);
                  e2_ff[0] <= sx(req.v2_x) - sx(req.v0_x);
                  e2_ff[1] <= sx(req.v2_y) - sx(req.v0_y);
                  e2_ff[2] <= sx(req.v2_z) - sx(req.v0_z);
                  tv_ff[0] <= sx(org_ff[0]) - sx(req.v0_x);
                  tv_ff[1] <= sx(org_ff[1]) - sx(req.v0_y);
                  tv_ff[2] <= sx(org_ff[2]) - sx(req.v0_z);
                  first_ff <= req.first_of_query;
               end
               OpCross: begin
                  if (cmd.sel == 2'd0) p_ff <= cr;
                  else q_ff <= cr;
               end
               OpDot: begin
                  if (cmd.sel == 2'd0) begin
                     det_ff <= dt[0];
                     nu_ff  <= dt[1];
                     nv_ff  <= dt[2];
                     nt_ff  <= dt[3];
                  end else begin
                     det_ff <= det_ff + (dt[0] <<< 33);
                     nu_ff  <= nu_ff + (dt[1] <<< 33);
                     nv_ff  <= nv_ff + (dt[2] <<< 33);
                     nt_ff  <= nt_ff + (dt[3] <<< 33);
                  end
               end
               OpSign: begin
                  mag_ff <= mag_c;
                  hit_ff <= hit_c;
                  num_ff <= {nt_c[WideW-17:0], 16'd0};
                  rem_ff <= '0;
                  quo_ff <= '0;
                  ovf_ff <= 1'b0;
               end
               OpDivStep: begin
                  num_ff <= {num_ff[WideW-2:0], 1'b0};
                  ovf_ff <= ovf_ff | quo_ff[QuoW-1];
                  if (!rem_sub[WideW-1] || rem_sh[WideW-1]) begin
                     rem_ff <= rem_sub;
                     quo_ff <= {quo_ff[QuoW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[QuoW-2:0], 1'b0};
                  end
               end
               OpFinish: begin
                  logic bf;
                  logic [31:0] bt;
                  bf = first_ff ? 1'b0 : best_found_ff;
                  bt = first_ff ? '1 : best_t_ff;
                  if (hit_ff && (!bf || t_sat < bt)) begin
                     bf = 1'b1;
                     bt = t_sat;
                  end
                  best_found_ff <= bf;
                  best_t_ff <= bt;
                  rsp.hit <= hit_ff;
                  rsp.hit_t <= hit_ff ? t_sat : '0;
                  rsp.closest_valid <= bf;
                  rsp.closest_t <= bt;
               end
               default: ;
            endcase
         end
      end
   end

   assign sts.hit = hit_c;

endmodule

// ===== src/rtch_ctrl.sv =====
module rtch_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  rtch_pkg::sts_type sts,
   output rtch_pkg::cmd_type cmd
);
   import rtch_pkg::*;

   typedef enum logic [2:0] {
      Idle, CrossP, CrossQ, Dot, DotHi, Sign, Divide, Finish
   } state_type;

   state_type state_ff;
   logic [6:0] cnt_ff;
   logic       valid_ff;

   assign req_stall = (state_ff != Idle);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd = '{go: 1'b0, op: OpLoad, sel: 2'd0};
      case (state_ff)
         Idle:   cmd = '{go: req_valid && !req_stall, op: OpLoad, sel: 2'd0};
         CrossP: cmd = '{go: 1'b1, op: OpCross, sel: 2'd0};
         CrossQ: cmd = '{go: 1'b1, op: OpCross, sel: 2'd1};
         Dot:    cmd = '{go: 1'b1, op: OpDot, sel: 2'd0};
         DotHi:  cmd = '{go: 1'b1, op: OpDot, sel: 2'd1};
         Sign:   cmd = '{go: 1'b1, op: OpSign, sel: 2'd0};
         Divide: cmd = '{go: 1'b1, op: OpDivStep, sel: 2'd0};
         Finish: cmd = '{go: !(valid_ff && rsp_stall), op: OpFinish, sel: 2'd0};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Idle;
         cnt_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
         case (state_ff)
            Idle:   if (req_valid && !req_stall) state_ff <= CrossP;
            CrossP: state_ff <= CrossQ;
            CrossQ: state_ff <= Dot;
            Dot:    state_ff <= DotHi;
            DotHi:  state_ff <= Sign;
            Sign: begin
               cnt_ff <= '0;
               state_ff <= sts.hit ? Divide : Finish;
            end
            Divide: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(WideW - 1)) state_ff <= Finish;
            end
            Finish: if (!(valid_ff && rsp_stall)) begin
               valid_ff <= 1'b1;
               state_ff <= Idle;
            end
            default: state_ff <= Idle;
         endcase
      end
   end

endmodule

// ===== src/ray_triangle_closest_hit.sv =====
// Tests one configured ray against a stream of triangles, one item at a time. An item steps
// through the cross, dot and sign states and, on a hit, through the bit-serial divider that forms
// t one quotient bit per cycle over the 128-bit numerator; the Finish state also waits while
// the previous result is still stalled. The tracker of the closest hit restarts on an item
// with first_of_query set. Write configuration only while idle.
module ray_triangle_closest_hit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtch_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtch_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import rtch_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rtch_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   rtch_datapath u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req(req_data), .cmd, .sts, .rsp(rsp_data)
   );

endmodule
